[rtl/hsrr_pkg.sv]
`default_nettype none
package hsrr_pkg;

	localparam int TRANS_FRAC_BITS = 16;
	localparam int TW = TRANS_FRAC_BITS + 1;
	localparam int QW = 8 + TRANS_FRAC_BITS;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = TW;

	// about 0.1 in the transmission format
	localparam logic [TW-1:0] TRANS_FLOOR_RST = TW'(((1 << TRANS_FRAC_BITS) + 5) / 10);

	localparam logic [CFG_IDX_W-1:0] CFG_ATMOS_BLUE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ATMOS_GREEN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ATMOS_RED   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TRANS_FLOOR = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEVEL   = 3'd4;

	typedef struct packed {
		logic [7:0]    pix_blue;
		logic [7:0]    pix_green;
		logic [7:0]    pix_red;
		logic [TW-1:0] trans_value;
	} pix_in_t;

	typedef struct packed {
		logic [7:0] out_blue;
		logic [7:0] out_green;
		logic [7:0] out_red;
	} pix_out_t;

	// one color channel on its way through the divider chain
	typedef struct packed {
		logic [TW-1:0] rem;
		logic [QW-1:0] quo;
		logic          neg;
		logic [7:0]    pix;
	} lane_t;

	typedef struct packed {
		logic          vld;
		logic [TW-1:0] den;
		lane_t [2:0]   lane;
	} cell_t;

endpackage
`default_nettype wire

[rtl/haze_scene_radiance_recovery_core.sv]
// haze removal, scene radiance recovery for one pixel per request
// pix channel: blue, green, red and transmission (16 fraction bits, 65536 = 1.0)
// res channel: recovered blue, green and red, one result per pixel, in order
// both channels use valid/stall; a request moves when valid is high and stall low
// transmission is raised to trans_floor, then each channel is
// floor((I - A) / t) + A, replaced by I above max_level and by 0 below zero
// pipeline: the front stage, loaded at the accepting edge, then 24 divider cells and
// one output register; the cell count follows from the quotient width of 8 plus
// the transmission fraction bits
// throughput: one pixel per clock while pix_stall is low, all three channels
// divided side by side in every cell of the chain
// when res is stalled a one-entry skid register catches the pixel leaving the
// chain; while it is full pix_stall is high and the chain holds its contents
// reset clears all valid bits and loads the default configuration
// configuration is written through cfg_we/cfg_index/cfg_data while idle (the block does not enforce it)
`default_nettype none
module haze_scene_radiance_recovery_core (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                pix_valid,
	output logic                               pix_stall,
	input  hsrr_pkg::pix_in_t                  pix,
	output logic                               res_valid,
	input  wire                                res_stall,
	output hsrr_pkg::pix_out_t                 res,
	input  wire                                cfg_we,
	input  wire [hsrr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire [hsrr_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import hsrr_pkg::*;

	// configuration registers
	logic [7:0]    atmos_blue_q;
	logic [7:0]    atmos_green_q;
	logic [7:0]    atmos_red_q;
	logic [TW-1:0] trans_floor_q;
	logic [7:0]    max_level_q;

	// chain of divider cells, entry 0 is the front stage
	cell_t         chain [QW+1];
	cell_t         front_n;
	logic          front_vld_q;
	logic [TW-1:0] front_den_q;
	lane_t [2:0]   front_lane_q;
	logic          en;
	logic          accept;

	// output side
	pix_out_t      res_n;
	pix_out_t      res_q;
	pix_out_t      skid_q;
	logic          res_valid_q;
	logic          skid_vld_q;
	logic          out_free;
	logic          load_skid;

	logic [7:0]    pix_ch [3];
	logic [7:0]    atm_ch [3];
	logic [7:0]    res_ch [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			atmos_blue_q  <= 8'd200;
			atmos_green_q <= 8'd200;
			atmos_red_q   <= 8'd200;
			trans_floor_q <= TRANS_FLOOR_RST;
			max_level_q   <= 8'd220;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ATMOS_BLUE: begin
					atmos_blue_q <= cfg_data[7:0];
				end
				CFG_ATMOS_GREEN: begin
					atmos_green_q <= cfg_data[7:0];
				end
				CFG_ATMOS_RED: begin
					atmos_red_q <= cfg_data[7:0];
				end
				CFG_TRANS_FLOOR: begin
					trans_floor_q <= cfg_data[TW-1:0];
				end
				CFG_MAX_LEVEL: begin
					max_level_q <= cfg_data[7:0];
				end
				default: begin
				end
			endcase
		end
	end

	// the whole chain moves while the skid register is empty
	assign en = !skid_vld_q;
	assign pix_stall = skid_vld_q;
	assign accept = pix_valid && en;

	assign pix_ch[0] = pix.pix_blue;
	assign pix_ch[1] = pix.pix_green;
	assign pix_ch[2] = pix.pix_red;
	assign atm_ch[0] = atmos_blue_q;
	assign atm_ch[1] = atmos_green_q;
	assign atm_ch[2] = atmos_red_q;

	// front stage: clamp the transmission, split each channel into sign and magnitude
	always_comb begin
		logic [TW-1:0] t_lim;
		logic          neg;
		logic [7:0]    mag;
		front_n.vld = accept;
		t_lim = (pix.trans_value < trans_floor_q) ? trans_floor_q : pix.trans_value;
		// zero transmission with a zero floor divides by the smallest code
		front_n.den = (t_lim == '0) ? TW'(1) : t_lim;
		for (int k = 0; k < 3; k++) begin
			neg = (pix_ch[k] < atm_ch[k]);
			mag = neg ? (atm_ch[k] - pix_ch[k]) : (pix_ch[k] - atm_ch[k]);
			front_n.lane[k].rem = '0;
			front_n.lane[k].quo = {mag, {TRANS_FRAC_BITS{1'b0}}};
			front_n.lane[k].neg = neg;
			front_n.lane[k].pix = pix_ch[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_vld_q <= 1'b0;
		end else if (en) begin
			front_vld_q <= front_n.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			front_den_q <= front_n.den;
			front_lane_q <= front_n.lane;
		end
	end

	assign chain[0].vld = front_vld_q;
	assign chain[0].den = front_den_q;
	assign chain[0].lane = front_lane_q;

	// one quotient bit per cell
	for (genvar i = 0; i < QW; i++) begin : g_cell
		hsrr_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.cin    (chain[i]),
			.cout   (chain[i+1])
		);
	end

	// floor correction, offset by the atmospheric light and range handling
	for (genvar k = 0; k < 3; k++) begin : g_fix
		hsrr_fix u_fix (
			.lane    (chain[QW].lane[k]),
			.atm     (atm_ch[k]),
			.max_lvl (max_level_q),
			.res     (res_ch[k])
		);
	end

	assign res_n.out_blue  = res_ch[0];
	assign res_n.out_green = res_ch[1];
	assign res_n.out_red   = res_ch[2];

	// output register with a one-entry skid behind it
	assign out_free = !res_valid_q || !res_stall;
	assign load_skid = !out_free && !skid_vld_q && chain[QW].vld;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			skid_vld_q  <= 1'b0;
		end else if (out_free) begin
			res_valid_q <= skid_vld_q || chain[QW].vld;
			skid_vld_q  <= 1'b0;
		end else if (load_skid) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			res_q <= skid_vld_q ? skid_q : res_n;
		end
		if (load_skid) begin
			skid_q <= res_n;
		end
	end

	assign res_valid = res_valid_q;
	assign res = res_q;

endmodule
`default_nettype wire

[rtl/hsrr_cell.sv]
`default_nettype none
module hsrr_cell (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 en,
	input  hsrr_pkg::cell_t     cin,
	output hsrr_pkg::cell_t     cout
);
	import hsrr_pkg::*;

	lane_t [2:0]   lane_n;
	logic          vld_q;
	logic [TW-1:0] den_q;
	lane_t [2:0]   lane_q;

	// one restoring division step on each of the three lanes
	always_comb begin
		logic [TW:0]   trial;
		logic [TW-1:0] diff;
		logic          ge;
		lane_n = cin.lane;
		for (int k = 0; k < 3; k++) begin
			trial = {cin.lane[k].rem, cin.lane[k].quo[QW-1]};
			// only used when trial >= den, so the low bits hold the full difference
			diff = trial[TW-1:0] - cin.den;
			ge = (trial >= {1'b0, cin.den});
			lane_n[k].rem = ge ? diff : trial[TW-1:0];
			lane_n[k].quo = {cin.lane[k].quo[QW-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= cin.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_q <= cin.den;
			lane_q <= lane_n;
		end
	end

	assign cout.vld = vld_q;
	assign cout.den = den_q;
	assign cout.lane = lane_q;

endmodule
`default_nettype wire

[rtl/hsrr_fix.sv]
`default_nettype none
module hsrr_fix (
	input  hsrr_pkg::lane_t lane,
	input  wire [7:0]       atm,
	input  wire [7:0]       max_lvl,
	output logic [7:0]      res
);
	import hsrr_pkg::*;

	logic [QW:0]          mag1;
	logic signed [QW+1:0] q_s;
	logic signed [QW+1:0] j_s;
	logic signed [QW+1:0] max_s;

	// floor division: a negative quotient with a remainder rounds one further down
	always_comb begin
		mag1 = {1'b0, lane.quo} + {{QW{1'b0}}, (lane.neg & (|lane.rem))};
		q_s = lane.neg ? -$signed({1'b0, mag1}) : $signed({1'b0, mag1});
		j_s = q_s + $signed({{(QW-6){1'b0}}, atm});
		max_s = $signed({{(QW-6){1'b0}}, max_lvl});
		if (j_s > max_s) begin
			res = lane.pix;
		end else if (j_s < 0) begin
			res = 8'd0;
		end else begin
			res = j_s[7:0];
		end
	end

endmodule
`default_nettype wire

[rtl/hsrr_chk.sv]
`default_nettype none
module hsrr_chk (
	input wire                 clk,
	input wire                 arst_n,
	input wire                 pix_stall,
	input wire                 res_valid,
	input wire                 res_stall,
	input hsrr_pkg::pix_out_t  res
);
	import hsrr_pkg::*;

	// a stalled result stays put
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("result changed while stalled");

	// input backpressure only starts after the output was stalled
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(pix_stall) |-> $past(res_valid && res_stall))
		else $error("input stalled without output backpressure");

	// the skid entry is only full behind a full output register
	a_skid_behind: assert property (@(posedge clk) disable iff (!arst_n)
		pix_stall |-> res_valid)
		else $error("input stalled with no pending result");

	// once the output is taken the skid drains in the next cycle
	a_skid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		pix_stall && !res_stall |=> !pix_stall)
		else $error("skid entry did not drain");

endmodule

bind haze_scene_radiance_recovery_core hsrr_chk u_hsrr_chk (.*);
`default_nettype wire

[test/tb_haze_scene_radiance_recovery_core.sv]
`default_nettype none
module tb_haze_scene_radiance_recovery_core;
	timeunit 1ns;
	timeprecision 1ps;

	import hsrr_pkg::*;

	// generous bound on the whole run, far above the slowest correct one
	localparam int CYCLE_LIMIT = 400000;
	// cycles from the accepting edge to res_valid, with some margin
	localparam int PIPE_DRAIN = 40;
	// random requests per random phase, four phases
	localparam int PHASE_ITEMS = 175;
	// long receiver hold-off so the chain and the skid register fill up
	localparam int HOLD_CYCLES = 300;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  pix_valid = 1'b0;
	logic                  pix_stall;
	pix_in_t               pix = '0;
	logic                  res_valid;
	logic                  res_stall = 1'b0;
	pix_out_t              res;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	haze_scene_radiance_recovery_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.pix       (pix),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// own copy of the configuration, loaded with the reset defaults
	logic [7:0]    atm_b   = 8'd200;
	logic [7:0]    atm_g   = 8'd200;
	logic [7:0]    atm_r   = 8'd200;
	logic [TW-1:0] floor_t = TW'(6554);
	logic [7:0]    max_lvl = 8'd220;

	pix_in_t  pix_todo[$];    // requests waiting for the driver
	pix_out_t radiance_q[$];  // recovered pixels still to come out
	logic     all_in = 1'b1;  // registered: nothing left in radiance_q
	int       errors = 0;
	int       res_seen = 0;
	int       cycles = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run bound
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// one channel: A + floor((I - A) * 2^frac / t), exact in integers
	function automatic logic [7:0] recover_level(logic [7:0] lvl, logic [7:0] atm,
			logic [TW-1:0] t);
		longint diff, num, den, quo, lev;
		diff = longint'(lvl) - longint'(atm);
		num = diff * (longint'(1) << TRANS_FRAC_BITS);
		den = longint'(t);
		quo = num / den;
		// division truncates toward zero, step down for negative remainders
		if ((num % den) != 0 && num < 0)
			quo = quo - 1;
		lev = quo + longint'(atm);
		// above the ceiling the hazy value is kept, below zero clamps
		if (lev > longint'(max_lvl))
			return lvl;
		if (lev < 0)
			return 8'd0;
		return lev[7:0];
	endfunction

	function automatic pix_out_t recover_pixel(pix_in_t p);
		pix_out_t      r;
		logic [TW-1:0] t;
		t = p.trans_value;
		if (t < floor_t)
			t = floor_t;
		// zero transmission with a zero floor uses the smallest code
		if (t == '0)
			t = TW'(1);
		r.out_blue  = recover_level(p.pix_blue, atm_b, t);
		r.out_green = recover_level(p.pix_green, atm_g, t);
		r.out_red   = recover_level(p.pix_red, atm_r, t);
		return r;
	endfunction

	task automatic report_mismatch(input string field, input logic [7:0] got,
			input logic [7:0] want);
		$display("mismatch at result %0d: %s got %0d want %0d", res_seen, field, got, want);
		errors++;
	endtask

	// monitor: predicts on accepted requests, checks accepted results
	always @(posedge clk or negedge arst_n) begin
		pix_out_t want;
		if (!arst_n) begin
			all_in <= 1'b1;
		end else begin
			if (res_valid && !res_stall) begin
				if (radiance_q.size() == 0) begin
					report_mismatch("unexpected result, blue", res.out_blue, 8'd0);
				end else begin
					want = radiance_q.pop_front();
					if (res.out_blue !== want.out_blue)
						report_mismatch("out_blue", res.out_blue, want.out_blue);
					if (res.out_green !== want.out_green)
						report_mismatch("out_green", res.out_green, want.out_green);
					if (res.out_red !== want.out_red)
						report_mismatch("out_red", res.out_red, want.out_red);
				end
				res_seen++;
			end
			if (pix_valid && !pix_stall)
				radiance_q.insert(radiance_q.size(), recover_pixel(pix));
			all_in <= (radiance_q.size() == 0);
		end
	end

	// driver: offers pending requests with random gaps, holds while stalled
	int  snd_gap = 0;
	int  snd_burst = 0;
	int  snd_count = 0;
	bit  snd_pause = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_valid <= 1'b0;
			pix       <= '0;
		end else begin
			// a pause lasts until every expected result has come back
			if (snd_pause && all_in)
				snd_pause = 1'b0;
			if (pix_valid && !pix_stall) begin
				snd_count++;
				if (snd_count % 100 == 50)
					snd_pause = 1'b1;
				if (snd_burst > 0) begin
					snd_burst--;
					snd_gap = 0;
				end else begin
					snd_gap = $urandom_range(0, 9);
					if ($urandom_range(0, 24) == 0)
						snd_burst = $urandom_range(20, 60);
				end
			end
			if (pix_valid && pix_stall) begin
				// stalled request stays as it is
			end else if (snd_pause || snd_gap > 0 || pix_todo.size() == 0) begin
				if (!snd_pause && snd_gap > 0)
					snd_gap--;
				pix_valid <= 1'b0;
			end else begin
				pix       <= pix_todo.pop_front();
				pix_valid <= 1'b1;
			end
		end
	end

	// receiver: random stall after each result, now and then a long hold-off
	int rcv_gap = 0;
	int rcv_burst = 0;
	int rcv_hold = 0;
	int rcv_taken = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
		end else begin
			if (res_valid && !res_stall) begin
				rcv_taken++;
				if (rcv_taken % 300 == 150) begin
					rcv_hold = HOLD_CYCLES;
				end else if (rcv_burst > 0) begin
					rcv_burst--;
					rcv_gap = 0;
				end else begin
					rcv_gap = $urandom_range(0, 9);
					if ($urandom_range(0, 24) == 0)
						rcv_burst = $urandom_range(20, 60);
				end
			end
			if (rcv_hold > 0) begin
				rcv_hold--;
				res_stall <= 1'b1;
			end else if (rcv_gap > 0) begin
				rcv_gap--;
				res_stall <= 1'b1;
			end else begin
				res_stall <= 1'b0;
			end
		end
	end

	// register write, model copy follows at once since the block is idle
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		case (idx)
			CFG_ATMOS_BLUE:  atm_b   = data[7:0];
			CFG_ATMOS_GREEN: atm_g   = data[7:0];
			CFG_ATMOS_RED:   atm_r   = data[7:0];
			CFG_TRANS_FLOOR: floor_t = data[TW-1:0];
			CFG_MAX_LEVEL:   max_lvl = data[7:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// 8-bit registers get junk in the unused upper data bits
	task automatic write_level(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] v);
		write_reg(idx, {(CFG_DATA_W-8)'($urandom), v});
	endtask

	task automatic push_pix(input logic [7:0] b, input logic [7:0] g, input logic [7:0] r,
			input logic [TW-1:0] t);
		pix_in_t p;
		p.pix_blue    = b;
		p.pix_green   = g;
		p.pix_red     = r;
		p.trans_value = t;
		pix_todo.insert(pix_todo.size(), p);
	endtask

	function automatic logic [7:0] pick_level();
		if ($urandom_range(0, 7) == 0)
			return $urandom_range(0, 1) ? 8'hff : 8'h00;
		return 8'($urandom);
	endfunction

	function automatic pix_in_t make_pixel();
		pix_in_t p;
		p.pix_blue  = pick_level();
		p.pix_green = pick_level();
		p.pix_red   = pick_level();
		case ($urandom_range(0, 7))
			0: p.trans_value = TW'($urandom);                    // whole field, above one too
			1: p.trans_value = TW'($urandom_range(0, floor_t));  // at or under the floor
			2: p.trans_value = TW'(1 << TRANS_FRAC_BITS);        // exactly one
			default: p.trans_value = TW'($urandom_range(1, 1 << TRANS_FRAC_BITS));
		endcase
		return p;
	endfunction

	// idle: nothing pending, nothing offered, every result back
	task automatic wait_drained();
		while (pix_todo.size() != 0 || pix_valid || !all_in)
			@(negedge clk);
	endtask

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed, reset configuration: floor about 0.1, A 200, ceiling 220
		@(negedge clk);
		push_pix(8'd0, 8'd0, 8'd0, TW'(0));
		push_pix(8'd255, 8'd255, 8'd255, TW'(65536));
		push_pix(8'd200, 8'd200, 8'd200, TW'(100));
		push_pix(8'd255, 8'd128, 8'd0, TW'(6554));
		push_pix(8'd199, 8'd201, 8'd0, TW'(6553));
		push_pix(8'd10, 8'd220, 8'd255, TW'(131071));
		push_pix(8'd0, 8'd255, 8'd0, TW'(32768));
		push_pix(8'd255, 8'd0, 8'd255, TW'(1));
		push_pix(8'd100, 8'd150, 8'd250, TW'(65535));
		push_pix(8'd221, 8'd219, 8'd220, TW'(65536));
		wait_drained();

		// directed, zero floor so a zero transmission becomes the smallest code
		write_level(CFG_ATMOS_BLUE, 8'd0);
		write_level(CFG_ATMOS_GREEN, 8'd255);
		write_level(CFG_ATMOS_RED, 8'd128);
		write_reg(CFG_TRANS_FLOOR, '0);
		write_level(CFG_MAX_LEVEL, 8'd255);
		@(negedge clk);
		push_pix(8'd0, 8'd0, 8'd0, TW'(0));
		push_pix(8'd255, 8'd255, 8'd255, TW'(0));
		push_pix(8'd1, 8'd254, 8'd127, TW'(0));
		push_pix(8'd128, 8'd128, 8'd128, TW'(1));
		push_pix(8'd255, 8'd0, 8'd129, TW'(2));
		push_pix(8'd0, 8'd255, 8'd255, TW'(65536));
		push_pix(8'd255, 8'd255, 8'd0, TW'(131071));
		push_pix(8'd17, 8'd200, 8'd3, TW'(65537));
		push_pix(8'd129, 8'd127, 8'd128, TW'(0));
		wait_drained();

		// random phases, each under its own configuration
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					write_level(CFG_ATMOS_BLUE, 8'($urandom));
					write_level(CFG_ATMOS_GREEN, 8'($urandom));
					write_level(CFG_ATMOS_RED, 8'($urandom));
					write_reg(CFG_TRANS_FLOOR, CFG_DATA_W'($urandom_range(1, 65536)));
					write_level(CFG_MAX_LEVEL, 8'($urandom));
				end
				1: begin
					// extremes: smallest floor, zero ceiling
					write_level(CFG_ATMOS_BLUE, 8'd255);
					write_level(CFG_ATMOS_GREEN, 8'd0);
					write_level(CFG_ATMOS_RED, 8'd255);
					write_reg(CFG_TRANS_FLOOR, CFG_DATA_W'(1));
					write_level(CFG_MAX_LEVEL, 8'd0);
				end
				2: begin
					// floor above one, taken as it is
					write_level(CFG_ATMOS_BLUE, 8'($urandom_range(128, 255)));
					write_level(CFG_ATMOS_GREEN, 8'($urandom_range(128, 255)));
					write_level(CFG_ATMOS_RED, 8'($urandom_range(128, 255)));
					write_reg(CFG_TRANS_FLOOR, CFG_DATA_W'($urandom_range(65537, 131071)));
					write_level(CFG_MAX_LEVEL, 8'd255);
				end
				default: begin
					// typical haze: bright airlight, low floor
					write_level(CFG_ATMOS_BLUE, 8'($urandom_range(150, 255)));
					write_level(CFG_ATMOS_GREEN, 8'($urandom_range(150, 255)));
					write_level(CFG_ATMOS_RED, 8'($urandom_range(150, 255)));
					write_reg(CFG_TRANS_FLOOR, CFG_DATA_W'($urandom_range(1, 16384)));
					write_level(CFG_MAX_LEVEL, 8'($urandom_range(180, 255)));
				end
			endcase
			@(negedge clk);
			for (int n = 0; n < PHASE_ITEMS; n++)
				pix_todo.insert(pix_todo.size(), make_pixel());
			wait_drained();
		end

		// catch any stray result after the last one
		repeat (PIPE_DRAIN) @(posedge clk);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
`default_nettype wire
